FILE: rtl/antialiased_disc_coverage_defines.svh
// ----------------------------------------------------------------------------
// antialiased_disc_coverage_defines.svh
// Assertion macros shared by the disc coverage RTL.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_DISC_COVERAGE_DEFINES_SVH
`define ANTIALIASED_DISC_COVERAGE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define ADC_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ADC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/adc_pkg.sv
// ----------------------------------------------------------------------------
// adc_pkg
// Types, constants and controller codes of the disc coverage block.
// ----------------------------------------------------------------------------
package adc_pkg;

	localparam int MAX_RADIUS16 = 48;
	localparam int SUBSAMPLES   = 16;
	localparam int STORE_DEPTH  = 128;
	localparam int STORE_AW     = 7;
	localparam int HW_W         = 6;
	localparam int CFG_W        = 13;
	localparam logic [CFG_W-1:0] CANVAS_MAX = 13'd4096;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CANVAS_WIDTH  = 1'b0;
	localparam cfg_idx_t CFG_CANVAS_HEIGHT = 1'b1;

	typedef struct packed {
		logic [15:0] center_x16;
		logic [15:0] center_y16;
		logic [5:0]  radius16;
	} dot_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [8:0]  coverage;
		logic        last;
	} pix_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BOX1,
		S_BOX2,
		S_CHECK,
		S_RB_PREP,
		S_RB_SQRT,
		S_RB_WRITE,
		S_FETCH,
		S_CALC,
		S_SUM
	} state_t;

	typedef struct packed {
		logic load;
		logic rb_start;
		logic rb_prep;
		logic rb_step;
		logic rb_write;
		logic rb_done;
		logic row_first;
		logic row_next;
		logic fetch;
		logic calc;
		logic emit;
		logic next_col;
	} cmd_t;

	typedef struct packed {
		logic need_rebuild;
		logic empty;
		logic idx_last;
		logic sqrt_last;
		logic fetch_last;
		logic col_last;
		logic row_last;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/adc_dot_if.sv
// ----------------------------------------------------------------------------
// adc_dot_if
// Valid/ready channel carrying one dot per beat.
// ----------------------------------------------------------------------------
interface adc_dot_if import adc_pkg::*; ();
	logic valid;
	logic ready;
	dot_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/adc_pix_if.sv
// ----------------------------------------------------------------------------
// adc_pix_if
// Valid/ready channel carrying one covered pixel per beat.
// ----------------------------------------------------------------------------
interface adc_pix_if import adc_pkg::*; ();
	logic valid;
	logic ready;
	pix_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/adc_ram.sv
// ----------------------------------------------------------------------------
// adc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adc_ram #(
	parameter int W = 6,
	parameter int D = 128
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/adc_ctrl.sv
// ----------------------------------------------------------------------------
// adc_ctrl
// Sequencer: box setup, half-width store rebuild, row fetch and pixel emit.
// ----------------------------------------------------------------------------
`include "antialiased_disc_coverage_defines.svh"

module adc_ctrl import adc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic dot_valid,
	output logic dot_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		dot_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				dot_ready = 1'b1;
				if (dot_valid) begin
					cmd.load = 1'b1;
					state_d  = S_BOX1;
				end
			end
			S_BOX1: begin
				state_d = S_BOX2;
			end
			S_BOX2: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.need_rebuild) begin
					cmd.rb_start = 1'b1;
					state_d      = S_RB_PREP;
				end else if (sts.empty) begin
					state_d = S_IDLE;
				end else begin
					cmd.row_first = 1'b1;
					state_d       = S_FETCH;
				end
			end
			S_RB_PREP: begin
				cmd.rb_prep = 1'b1;
				state_d     = S_RB_SQRT;
			end
			S_RB_SQRT: begin
				cmd.rb_step = 1'b1;
				if (sts.sqrt_last) begin
					state_d = S_RB_WRITE;
				end
			end
			S_RB_WRITE: begin
				cmd.rb_write = 1'b1;
				if (sts.idx_last) begin
					cmd.rb_done = 1'b1;
					if (sts.empty) begin
						state_d = S_IDLE;
					end else begin
						cmd.row_first = 1'b1;
						state_d       = S_FETCH;
					end
				end else begin
					state_d = S_RB_PREP;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				if (sts.fetch_last) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.col_last) begin
						if (sts.row_last) begin
							state_d = S_IDLE;
						end else begin
							cmd.row_next = 1'b1;
							state_d      = S_FETCH;
						end
					end else begin
						cmd.next_col = 1'b1;
						state_d      = S_CALC;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`ADC_ASSERT_NEXT(a_load_to_box, dot_valid && dot_ready, state_q == S_BOX1, "dot not boxed")
	`ADC_ASSERT_SAME(a_emit_last_idle, cmd.emit && sts.col_last && sts.row_last, state_d == S_IDLE, "last pixel does not end dot")
	`ADC_ASSERT_SAME(a_write_after_sqrt, cmd.rb_write, $past(state_q) == S_RB_SQRT, "store written without root")

endmodule

FILE: rtl/adc_dp.sv
// ----------------------------------------------------------------------------
// adc_dp
// Datapath: canvas registers, box clipping, half-width store and its root
// unit, sub-row lanes, coverage adder and output register.
// ----------------------------------------------------------------------------
`include "antialiased_disc_coverage_defines.svh"

module adc_dp import adc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  dot_t             dot_data,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             pix_valid,
	output pix_t             pix_data,
	input  logic             pix_ready
);

	// one sub-row contribution: left of, in, or right of the centre column
	function automatic logic [4:0] lane_cov(logic [HW_W-1:0] a, logic signed [9:0] x,
			logic is_left, logic is_mid);
		logic signed [9:0] a10;
		logic signed [9:0] sp;
		logic signed [9:0] sm;
		logic signed [9:0] v;
		logic signed [9:0] hi;
		a10 = $signed({4'b0, a});
		sp  = 10'sd16 + a10 + x;
		sm  = a10 - x;
		hi  = 10'sd16;
		if (is_left) begin
			v = sp;
		end else if (is_mid && (x + a10 < 10'sd0)) begin
			v  = sp;
			hi = a10 + a10;
		end else begin
			v = sm;
		end
		if (v < 10'sd0) begin
			v = 10'sd0;
		end
		if (v > hi) begin
			v = hi;
		end
		return v[4:0];
	endfunction

	// configuration
	logic [CFG_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CANVAS_MAX;
			height_q <= CANVAS_MAX;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_CANVAS_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	// latched dot, radius saturated
	logic [15:0]     cx_q, cy_q;
	logic [HW_W-1:0] r_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= dot_data.center_x16;
			cy_q <= dot_data.center_y16;
			r_q  <= (dot_data.radius16 > HW_W'(MAX_RADIUS16)) ? HW_W'(MAX_RADIUS16)
				: dot_data.radius16;
		end
	end

	// box, first stage: clip bounds
	logic [CFG_W-1:0] wclip, hclip, maxx_raw, maxy_raw, maxx_c, maxy_c;
	logic [15:0]      dx, dy, xneg_full;
	logic [16:0]      sx, sy;
	logic [11:0]      minx_c, miny_c;

	always_comb begin
		wclip    = (width_q > CANVAS_MAX) ? CANVAS_MAX : width_q;
		hclip    = (height_q > CANVAS_MAX) ? CANVAS_MAX : height_q;
		dx       = cx_q - {10'd0, r_q};
		dy       = cy_q - {10'd0, r_q};
		minx_c   = (cx_q < {10'd0, r_q}) ? 12'd0 : dx[15:4];
		miny_c   = (cy_q < {10'd0, r_q}) ? 12'd0 : dy[15:4];
		sx       = {1'b0, cx_q} + {11'd0, r_q} + 17'd15;
		sy       = {1'b0, cy_q} + {11'd0, r_q} + 17'd15;
		maxx_raw = sx[16:4];
		maxy_raw = sy[16:4];
		maxx_c   = (maxx_raw > wclip - 13'd1) ? wclip - 13'd1 : maxx_raw;
		maxy_c   = (maxy_raw > hclip - 13'd1) ? hclip - 13'd1 : maxy_raw;
		xneg_full = cx_q - {minx_c, 4'b0};
	end

	logic [11:0]      minx_s1, miny_s1;
	logic [CFG_W-1:0] maxx_s1, maxy_s1;
	logic [5:0]       xneg_s1;
	logic             zero_s1;

	always_ff @(posedge clk) begin
		minx_s1 <= minx_c;
		miny_s1 <= miny_c;
		maxx_s1 <= maxx_c;
		maxy_s1 <= maxy_c;
		xneg_s1 <= xneg_full[5:0];
		zero_s1 <= (width_q == '0) || (height_q == '0);
	end

	// box, second stage: counts, centre column, first store row
	logic [CFG_W-1:0]    cdiff, rdiff;
	logic [3:0]          ncm1, mid_raw;
	logic [6:0]          mid_sum;
	logic [3:0]          ncols_s2, nrows_s2, midoff_s2;
	logic                empty_s2;
	logic [STORE_AW-1:0] base0_s2;

	always_comb begin
		cdiff   = maxx_s1 - {1'b0, minx_s1};
		rdiff   = maxy_s1 - {1'b0, miny_s1};
		ncm1    = cdiff[3:0] - 4'd1;
		mid_sum = 7'd15 + {1'b0, xneg_s1};
		mid_raw = {1'b0, mid_sum[6:4]};
	end

	always_ff @(posedge clk) begin
		empty_s2  <= zero_s1 || ({1'b0, minx_s1} >= maxx_s1) || ({1'b0, miny_s1} >= maxy_s1);
		ncols_s2  <= cdiff[3:0];
		nrows_s2  <= rdiff[3:0];
		midoff_s2 <= (mid_raw > ncm1) ? ncm1 : mid_raw;
		base0_s2  <= {miny_s1[2:0], 4'b0} - cy_q[STORE_AW-1:0] + 7'd16 + {1'b0, r_q};
	end

	// held radius and store validity
	logic [HW_W-1:0] held_q;
	logic            tv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			tv_q   <= 1'b0;
		end else if (cmd.rb_done) begin
			held_q <= r_q;
			tv_q   <= 1'b1;
		end
	end

	// rebuild: one entry per pass, restoring root one bit a cycle
	logic [STORE_AW-1:0] idx_q;
	logic [11:0]         n_q;
	logic [HW_W-1:0]     root_q;
	logic [2:0]          bit_q;
	logic signed [8:0]   yr;
	logic [7:0]          yabs;
	logic [15:0]         ysq;
	logic [11:0]         rsq;
	logic [HW_W-1:0]     trial;
	logic [11:0]         trial_sq;

	always_comb begin
		yr       = $signed({2'b0, idx_q}) - $signed({3'b0, r_q} + 9'd16);
		yabs     = yr[8] ? 8'(-yr) : yr[7:0];
		ysq      = yabs * yabs;
		rsq      = r_q * r_q;
		trial    = root_q | (HW_W'(1) << bit_q);
		trial_sq = trial * trial;
	end

	always_ff @(posedge clk) begin
		if (cmd.rb_start) begin
			idx_q <= '0;
		end else if (cmd.rb_write) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.rb_prep) begin
			n_q    <= (ysq > {4'b0, rsq}) ? 12'd0 : rsq - ysq[11:0];
			root_q <= '0;
			bit_q  <= 3'(HW_W - 1);
		end else if (cmd.rb_step) begin
			if (trial_sq <= n_q) begin
				root_q <= trial;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	// store
	logic [3:0]          row_q, col_q;
	logic [4:0]          k_q;
	logic [STORE_AW-1:0] base_q, raddr;
	logic [HW_W-1:0]     rdata;

	assign raddr = base_q + {3'b0, k_q[3:0]};

	adc_ram #(
		.W (HW_W),
		.D (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.rb_write),
		.waddr (idx_q),
		.wdata (root_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// row fetch into the sub-row lanes
	logic [HW_W-1:0] a_q [SUBSAMPLES];

	always_ff @(posedge clk) begin
		if (cmd.row_first) begin
			row_q  <= '0;
			base_q <= base0_s2;
		end else if (cmd.row_next) begin
			row_q  <= row_q + 4'd1;
			base_q <= base_q + 7'(SUBSAMPLES);
		end
		if (cmd.row_first || cmd.row_next) begin
			k_q   <= '0;
			col_q <= '0;
		end else begin
			if (cmd.fetch) begin
				k_q <= k_q + 5'd1;
				if (k_q != 5'd0) begin
					a_q[4'(k_q - 5'd1)] <= rdata;
				end
			end
			if (cmd.next_col) begin
				col_q <= col_q + 4'd1;
			end
		end
	end

	// lanes: one sub-row each
	logic signed [9:0] xpos;
	logic [4:0]        c_d [SUBSAMPLES];
	logic [4:0]        c_q [SUBSAMPLES];

	always_comb begin
		xpos = $signed({2'b0, col_q, 4'b0}) - $signed({4'b0, xneg_s1});
		for (int i = 0; i < SUBSAMPLES; i++) begin
			c_d[i] = lane_cov(a_q[i], xpos, col_q < midoff_s2, col_q == midoff_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			for (int i = 0; i < SUBSAMPLES; i++) begin
				c_q[i] <= c_d[i];
			end
		end
	end

	// coverage sum and output register
	logic [8:0] cov_sum;
	logic       col_last, row_last;

	always_comb begin
		cov_sum = '0;
		for (int i = 0; i < SUBSAMPLES; i++) begin
			cov_sum = cov_sum + {4'b0, c_q[i]};
		end
	end

	assign col_last = (col_q == ncols_s2 - 4'd1);
	assign row_last = (row_q == nrows_s2 - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (cmd.emit) begin
			pix_valid <= 1'b1;
		end else if (pix_ready) begin
			pix_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pix_data.pixel_x  <= minx_s1 + {8'b0, col_q};
			pix_data.pixel_y  <= miny_s1 + {8'b0, row_q};
			pix_data.coverage <= cov_sum;
			pix_data.last     <= col_last && row_last;
		end
	end

	always_comb begin
		sts.need_rebuild = !tv_q || (held_q != r_q);
		sts.empty        = empty_s2;
		sts.idx_last     = (idx_q == STORE_AW'(STORE_DEPTH - 1));
		sts.sqrt_last    = (bit_q == 3'd0);
		sts.fetch_last   = (k_q == 5'(SUBSAMPLES));
		sts.col_last     = col_last;
		sts.row_last     = row_last;
		sts.out_free     = !pix_valid || pix_ready;
	end

	`ADC_ASSERT_NEXT(a_emit_valid, cmd.emit, pix_valid, "emitted beat not presented")
	`ADC_ASSERT_SAME(a_emit_free, cmd.emit, !pix_valid || pix_ready, "output overwritten")
	`ADC_ASSERT_SAME(a_store_valid, $rose(tv_q), $past(cmd.rb_done), "store marked without rebuild")

endmodule

FILE: rtl/antialiased_disc_coverage.sv
// ----------------------------------------------------------------------------
// antialiased_disc_coverage
// Antialiased disc coverage on a 16x16 sub-pixel grid, one beat per pixel.
// ----------------------------------------------------------------------------
// A dot beat carries a centre and radius in 1/16 pixel. The block clips the
// pixel bounding box to the canvas and sends one pixel beat per box pixel,
// row by row, left to right, with a 0..256 coverage count and last set on
// the final pixel; an empty box sends nothing. One dot is worked at a time:
// box setup, then per box row a load of the 16 sub-row half-widths from
// the store (one read port), then per pixel the lane evaluation and the
// 16-input coverage add; a pixel waits while the pixel channel stalls.
// When the radius differs from the held one, or no store is held yet, the
// 128-entry half-width store is rebuilt first: per entry a prepare step,
// the bit-serial square root and a write. The finished pixel sits in an
// output register, so the next dot can be taken while the last pixel still
// waits. Canvas size registers (index 0 width, index 1 height) reset to
// 4096; the user must write them only while the block is idle, and the
// block does not enforce this. Values above 4096 clip as 4096, zero gives
// an empty box.
// ----------------------------------------------------------------------------
module antialiased_disc_coverage import adc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	adc_dot_if.sink          dot,
	adc_pix_if.source        pix,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: accepts a dot beat only between dots
	adc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.dot_valid (dot.valid),
		.dot_ready (dot.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: owns the store, lanes and output register
	adc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.dot_data  (dot.payload),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pix_valid (pix.valid),
		.pix_data  (pix.payload),
		.pix_ready (pix.ready)
	);

endmodule
